@@ rtl/multi_probe_window_statistics_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multi-probe window statistics core
// Wrappers for concurrent assertions; NO_ASSERTIONS turns them into nothing.
// ----------------------------------------------------------------------------
`ifndef MULTI_PROBE_WINDOW_STATISTICS_CORE_ASSERT_SVH
`define MULTI_PROBE_WINDOW_STATISTICS_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define MPWS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define MPWS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define MPWS_ASSERT(lbl, clk, rst, prop, msg)
`define MPWS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

@@ rtl/mpws_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-probe window statistics package
// Field widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mpws_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int SPW_W      = 10;
  localparam int RANGE_W    = 12;
  localparam int PROBE_W    = 2;
  localparam int MEAN_W     = 16;
  localparam int STD_W      = 15;
  localparam int SPREAD_W   = 16;
  localparam int TENTHS_W   = 14;
  localparam int Q_FRAC     = 4;
  localparam int DEV_SHIFT  = 8;
  localparam int PCT_NUM_W  = 26;
  localparam int DIVISOR_W  = RANGE_W + Q_FRAC;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RANGE_W;

  localparam int SPW_MAX    = 2 ** SPW_W - 1;
  localparam int SAMPLE_MAX = 2 ** SAMPLE_W - 1;
  localparam int PCT_SCALE  = 1000;
  localparam int TENTHS_MAX = 9999;

  localparam logic [SPW_W-1:0]   SPW_RESET   = 10'd100;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 12'd1481;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC_RANGE      = 1'b1;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_STD,
    DIV_PCT
  } div_sel_t;

  typedef struct packed {
    logic     acc;
    logic     prod;
    logic     sqrt_go;
    logic     div_go;
    div_sel_t div_sel;
    logic     cap_mean;
    logic     cap_std;
    logic     spread;
    logic     cap_pct;
    logic     load;
  } dp_cmd_t;

  typedef struct packed {
    logic win_end;
    logic last_probe;
    logic sqrt_busy;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/mpws_div.sv @@
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned quotient of DD_W bits, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mpws_div #(
  parameter int DD_W = 26,
  parameter int DS_W = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [DD_W-1:0] dividend,
  input  wire logic [DS_W-1:0] divisor,
  output logic                 busy,
  output logic [DD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DS_W-1:0]  rem;
  logic [DS_W-1:0]  dvs;
  logic [DS_W:0]    rem_sh;
  logic             fits;
  logic [DS_W:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem, quotient[DD_W-1]};
    fits    = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DD_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      // shift the next dividend bit in, keep the partial remainder below dvs
      quotient <= {quotient[DD_W-2:0], fits};
      rem      <= fits ? rem_sub[DS_W-1:0] : rem_sh[DS_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mpws_sqrt.sv @@
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mpws_sqrt #(
  parameter int RT_W = 26
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2*RT_W-1:0] x,
  output logic                   busy,
  output logic [RT_W-1:0]        root
);

  localparam int CNT_W = $clog2(RT_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [2*RT_W-1:0] xs;
  logic [RT_W+1:0]   rem;
  logic [RT_W+1:0]   rem_sh;
  logic [RT_W+1:0]   trial;
  logic              fits;

  always_comb begin
    // bring down the next bit pair; the remainder stays below 2^RT_W here
    rem_sh = {rem[RT_W-1:0], xs[2*RT_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(RT_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xs   <= {xs[2*RT_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[RT_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ rtl/mpws_dp.sv @@
// ----------------------------------------------------------------------------
// Window statistics datapath
// Accumulators, configuration, end-of-window arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_probe_window_statistics_core_assert.svh"

module mpws_dp
  import mpws_pkg::*;
#(
  parameter int PROBES     = 3,
  parameter int MAX_WINDOW = 1023
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  input  wire logic [SAMPLE_W-1:0]   sample,
  input  wire logic                  start_cycle,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic [PROBE_W-1:0]         probe,
  output logic [MEAN_W-1:0]          mean_q4,
  output logic [STD_W-1:0]           std_dev_q4,
  output logic [SAMPLE_W-1:0]        minimum,
  output logic [SAMPLE_W-1:0]        maximum,
  output logic [SPREAD_W-1:0]        spread_q4,
  output logic [TENTHS_W-1:0]        spread_tenths_pct,
  output logic                       cycle_done
);

  localparam int CNT_MAX    = (MAX_WINDOW < SPW_MAX) ? MAX_WINDOW : SPW_MAX;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);
  localparam int SUM_W      = SAMPLE_W + CNT_W;
  localparam int SQ_SMP_W   = 2 * SAMPLE_W;
  localparam int SQ_W       = SQ_SMP_W + CNT_W;
  localparam int P_W        = SQ_W + CNT_W;
  localparam int X_W        = P_W + DEV_SHIFT;
  localparam int RT_W       = (X_W + 1) / 2;
  localparam int MEAN_NUM_W = SUM_W + Q_FRAC;
  localparam int DD_A       = (MEAN_NUM_W > RT_W) ? MEAN_NUM_W : RT_W;
  localparam int DD_W       = (DD_A > PCT_NUM_W) ? DD_A : PCT_NUM_W;

  // configuration
  logic [SPW_W-1:0]   samples_per_window;
  logic [RANGE_W-1:0] dynamic_range;

  // window state
  logic [SUM_W-1:0]    sample_sum;
  logic [SQ_W-1:0]     square_sum;
  logic [SAMPLE_W-1:0] running_min;
  logic [SAMPLE_W-1:0] running_max;
  logic [CNT_W-1:0]    sample_count;
  logic [PROBE_W-1:0]  probe_index;
  logic [MEAN_W-1:0]   lowest_mean;
  logic [MEAN_W-1:0]   highest_mean;

  // accumulate path
  logic [SUM_W-1:0]    sum_next;
  logic [SQ_W-1:0]     sq_next;
  logic [SAMPLE_W-1:0] min_next;
  logic [SAMPLE_W-1:0] max_next;
  logic [CNT_W-1:0]    count_next;
  logic [SQ_SMP_W-1:0] sample_sq;
  logic [SPW_W-1:0]    spw_nz;
  logic [SPW_W-1:0]    spw_cap;
  logic [CNT_W-1:0]    len_eff;

  // end-of-window arithmetic
  logic [P_W-1:0]       prod_nsq;
  logic [P_W-1:0]       prod_ss;
  logic [P_W-1:0]       dev;
  logic [2*RT_W-1:0]    sqrt_x;
  logic                 sqrt_busy;
  logic [RT_W-1:0]      root;
  logic [DD_W-1:0]      div_dd;
  logic [DIVISOR_W-1:0] div_ds;
  logic                 div_busy;
  logic [DD_W-1:0]      quotient;
  logic [RANGE_W-1:0]   range_eff;
  logic [MEAN_W-1:0]    win_mean;
  logic [STD_W-1:0]     win_std;
  logic [SPREAD_W-1:0]  spread_val;
  logic [PCT_NUM_W-1:0] pct_num;
  logic [TENTHS_W-1:0]  win_pct;
  logic                 last_probe;

  assign sample_sq = SQ_SMP_W'(sample) * SQ_SMP_W'(sample);

  always_comb begin
    sum_next   = (start_cycle ? '0 : sample_sum) + SUM_W'(sample);
    sq_next    = (start_cycle ? '0 : square_sum) + SQ_W'(sample_sq);
    min_next   = start_cycle ? SAMPLE_W'(SAMPLE_MAX) : running_min;
    max_next   = start_cycle ? '0 : running_max;
    count_next = (start_cycle ? '0 : sample_count) + CNT_W'(1);
    if (sample < min_next) begin
      min_next = sample;
    end
    if (sample > max_next) begin
      max_next = sample;
    end
    // zero length acts as one; clamp to the longest window
    spw_nz  = (samples_per_window == '0) ? SPW_W'(1) : samples_per_window;
    spw_cap = (spw_nz > SPW_W'(CNT_MAX)) ? SPW_W'(CNT_MAX) : spw_nz;
    len_eff = spw_cap[CNT_W-1:0];
  end

  assign last_probe = probe_index >= PROBE_W'(PROBES - 1);
  assign range_eff  = (dynamic_range == '0) ? RANGE_W'(1) : dynamic_range;
  assign dev        = prod_nsq - prod_ss;
  assign sqrt_x     = (2*RT_W)'({dev, {DEV_SHIFT{1'b0}}});

  always_comb begin
    unique case (cmd.div_sel)
      DIV_MEAN: begin
        div_dd = DD_W'({sample_sum, {Q_FRAC{1'b0}}});
        div_ds = DIVISOR_W'(sample_count);
      end
      DIV_STD: begin
        div_dd = DD_W'(root);
        div_ds = DIVISOR_W'(sample_count);
      end
      DIV_PCT: begin
        div_dd = DD_W'(pct_num);
        div_ds = {range_eff, {Q_FRAC{1'b0}}};
      end
      default: begin
        div_dd = '0;
        div_ds = DIVISOR_W'(1);
      end
    endcase
  end

  mpws_sqrt #(
    .RT_W (RT_W)
  ) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_go),
    .x     (sqrt_x),
    .busy  (sqrt_busy),
    .root  (root)
  );

  mpws_div #(
    .DD_W (DD_W),
    .DS_W (DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (div_dd),
    .divisor  (div_ds),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign stat.win_end    = count_next >= len_eff;
  assign stat.last_probe = last_probe;
  assign stat.sqrt_busy  = sqrt_busy;
  assign stat.div_busy   = div_busy;
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_window <= SPW_RESET;
      dynamic_range      <= RANGE_RESET;
      sample_sum         <= '0;
      square_sum         <= '0;
      running_min        <= SAMPLE_W'(SAMPLE_MAX);
      running_max        <= '0;
      sample_count       <= '0;
      probe_index        <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SAMPLES_PER_WINDOW: samples_per_window <= cfg_data[SPW_W-1:0];
          REG_DYNAMIC_RANGE:      dynamic_range      <= cfg_data[RANGE_W-1:0];
        endcase
      end
      if (cmd.acc) begin
        sample_sum   <= sum_next;
        square_sum   <= sq_next;
        running_min  <= min_next;
        running_max  <= max_next;
        sample_count <= count_next;
        if (start_cycle) begin
          probe_index <= '0;
        end
      end
      // hand the window over to the result register and open the next one
      if (cmd.load) begin
        sample_sum   <= '0;
        square_sum   <= '0;
        running_min  <= SAMPLE_W'(SAMPLE_MAX);
        running_max  <= '0;
        sample_count <= '0;
        probe_index  <= last_probe ? '0 : probe_index + PROBE_W'(1);
        out_valid    <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod) begin
      prod_nsq <= P_W'(sample_count) * P_W'(square_sum);
      prod_ss  <= P_W'(sample_sum) * P_W'(sample_sum);
    end
    if (cmd.cap_mean) begin
      win_mean <= quotient[MEAN_W-1:0];
      if (probe_index == '0) begin
        lowest_mean  <= quotient[MEAN_W-1:0];
        highest_mean <= quotient[MEAN_W-1:0];
      end else begin
        if (quotient[MEAN_W-1:0] < lowest_mean) begin
          lowest_mean <= quotient[MEAN_W-1:0];
        end
        if (quotient[MEAN_W-1:0] > highest_mean) begin
          highest_mean <= quotient[MEAN_W-1:0];
        end
      end
    end
    if (cmd.cap_std) begin
      win_std <= quotient[STD_W-1:0];
    end
    if (cmd.spread) begin
      spread_val <= highest_mean - lowest_mean;
      pct_num    <= PCT_NUM_W'(highest_mean - lowest_mean) * PCT_NUM_W'(PCT_SCALE);
    end
    if (cmd.cap_pct) begin
      win_pct <= (quotient > DD_W'(TENTHS_MAX)) ? TENTHS_W'(TENTHS_MAX)
                                                : quotient[TENTHS_W-1:0];
    end
    if (cmd.load) begin
      probe             <= probe_index;
      mean_q4           <= win_mean;
      std_dev_q4        <= win_std;
      minimum           <= running_min;
      maximum           <= running_max;
      spread_q4         <= last_probe ? spread_val : '0;
      spread_tenths_pct <= last_probe ? win_pct : '0;
      cycle_done        <= last_probe;
    end
  end

  `MPWS_ASSERT(a_min_le_max, clk, rst, out_valid |-> (minimum <= maximum), "window minimum above maximum")
  `MPWS_ASSERT(a_spread_only_last, clk, rst, (out_valid && !cycle_done) |-> (spread_q4 == '0 && spread_tenths_pct == '0), "spread fields set outside last probe")

endmodule

`default_nettype wire

@@ rtl/mpws_ctrl.sv @@
// ----------------------------------------------------------------------------
// Window statistics controller
// Sequences accumulation and the end-of-window products, root and divisions.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_probe_window_statistics_core_assert.svh"

module mpws_ctrl
  import mpws_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_DIFF,
    S_ROOT,
    S_STD,
    S_SPREAD,
    S_PCT_GO,
    S_PCT,
    S_LOAD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_MEAN;
    unique case (state)
      S_IDLE: begin
        cmd.acc = in_valid;
        if (in_valid && stat.win_end) begin
          state_next = S_PROD;
        end
      end
      S_PROD: begin
        // products and the mean division start together
        cmd.prod    = 1'b1;
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_MEAN;
        state_next  = S_DIFF;
      end
      S_DIFF: begin
        cmd.sqrt_go = 1'b1;
        state_next  = S_ROOT;
      end
      S_ROOT: begin
        if (!stat.sqrt_busy && !stat.div_busy) begin
          cmd.cap_mean = 1'b1;
          cmd.div_go   = 1'b1;
          cmd.div_sel  = DIV_STD;
          state_next   = S_STD;
        end
      end
      S_STD: begin
        if (!stat.div_busy) begin
          cmd.cap_std = 1'b1;
          state_next  = stat.last_probe ? S_SPREAD : S_LOAD;
        end
      end
      S_SPREAD: begin
        cmd.spread = 1'b1;
        state_next = S_PCT_GO;
      end
      S_PCT_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_PCT;
        state_next  = S_PCT;
      end
      S_PCT: begin
        cmd.div_sel = DIV_PCT;
        if (!stat.div_busy) begin
          cmd.cap_pct = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= state_next != S_IDLE;
    end
  end

  `MPWS_ASSERT(a_div_not_busy, clk, rst, cmd.div_go |-> !stat.div_busy, "divider restarted while busy")
  `MPWS_ASSERT(a_acc_quiet, clk, rst, cmd.acc |-> (!stat.div_busy && !stat.sqrt_busy), "sample taken during window arithmetic")
  `MPWS_ASSERT_NEXT(a_end_stalls, clk, rst, cmd.acc && stat.win_end, in_stall, "input not stalled after window end")

endmodule

`default_nettype wire

@@ rtl/multi_probe_window_statistics_core.sv @@
// ----------------------------------------------------------------------------
// Multi-probe window statistics core
// Per-probe window mean, standard deviation, extremes and probe mean spread.
// ----------------------------------------------------------------------------
// Samples arrive one per cycle while a window fills: each accepted item is
// added to the sum, the sum of squares and the running extremes in the cycle
// it is taken. When the window reaches its length the input is stalled while
// the two products are formed and the one-bit-per-cycle square-root unit and
// shared divider (26 bits wide at the default window bound) run, and on the
// last probe of a cycle also while the divider does the percent division.
// The result sits in an output register, so a new window starts filling
// while it waits to be taken. Configuration writes are always ready and take
// effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_probe_window_statistics_core
  import mpws_pkg::*;
#(
  parameter int PROBES     = 3,
  parameter int MAX_WINDOW = 1023
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SAMPLE_W-1:0]   sample,
  input  wire logic                  start_cycle,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PROBE_W-1:0]         probe,
  output logic [MEAN_W-1:0]          mean_q4,
  output logic [STD_W-1:0]           std_dev_q4,
  output logic [SAMPLE_W-1:0]        minimum,
  output logic [SAMPLE_W-1:0]        maximum,
  output logic [SPREAD_W-1:0]        spread_q4,
  output logic [TENTHS_W-1:0]        spread_tenths_pct,
  output logic                       cycle_done,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  mpws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  mpws_dp #(
    .PROBES     (PROBES),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .sample            (sample),
    .start_cycle       (start_cycle),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .probe             (probe),
    .mean_q4           (mean_q4),
    .std_dev_q4        (std_dev_q4),
    .minimum           (minimum),
    .maximum           (maximum),
    .spread_q4         (spread_q4),
    .spread_tenths_pct (spread_tenths_pct),
    .cycle_done        (cycle_done)
  );

endmodule

`default_nettype wire
